// ----- design/gcl_pkg.sv -----
`default_nettype none

package gcl_pkg;

  // Field and datapath widths
  localparam int IDX_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int REG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int P_W      = 4;             // integer part of log2 (msb position <= 12)
  localparam int FRAC_W   = 16;            // fraction bits of log2 / exponent
  localparam int MANT_W   = 32;            // Q1.31 mantissa
  localparam int LOG_W    = P_W + FRAC_W;  // Q.16 log2
  localparam int T_W      = 25;            // scaled exponent, Q.16
  localparam int Q_W      = T_W - FRAC_W;  // integer part of the exponent
  localparam int SHAPED_W = 33;            // Q.32, up to exactly 1.0
  localparam int TERM_W   = 32;
  localparam int BASE_W   = 34;            // signed Q.28
  localparam int PROD_W   = 50;            // signed Q.40
  localparam int LVL_W    = 16;

  // Pipeline depth from accepted beat to level strobe
  localparam int PIPE_LAT = 40;

  localparam int MAX_ENTRIES_DEF = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MUL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MUL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MUL   = 3'd6;

  // Reset values
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 13'd1024;
  localparam logic [REG_W-1:0]  ONE_Q12        = 16'd4096;
  localparam logic [REG_W-1:0]  LIFT_RST       = 16'd0;

  // Tag that rides the delay line next to the datapath
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             zero;
  } gcl_tag_t;

  // 2^(-2^-k) as Q.32 constants, K[0] = 2^31, K[k] = isqrt(K[k-1] << 32)
  typedef logic [FRAC_W:1][MANT_W-1:0] k_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic k_tab_t k_table();
    k_tab_t      tab;
    logic [63:0] prev;
    prev = 64'h0000_0000_8000_0000;
    for (int k = 1; k <= FRAC_W; k++) begin
      prev   = isqrt64(prev << 32);
      tab[k] = prev[MANT_W-1:0];
    end
    return tab;
  endfunction

  localparam k_tab_t K_TAB = k_table();

endpackage

`default_nettype wire

// ----- design/gcl_log2.sv -----
`default_nettype none

// log2 in Q.16: msb search, then one mantissa squaring per stage (17 stages)
module gcl_log2 (
  input  logic                       clk,
  input  logic [gcl_pkg::SIZE_W-1:0] v,
  output logic [gcl_pkg::LOG_W-1:0]  log_val
);
  import gcl_pkg::*;

  logic [P_W-1:0]    pn;
  logic [MANT_W-1:0] mn;

  logic [P_W-1:0]    p_q [0:FRAC_W];
  logic [MANT_W-1:0] m_q [0:FRAC_W];
  logic [FRAC_W-1:0] f_q [0:FRAC_W];

  // normalize: msb position and Q1.31 mantissa
  always_comb begin
    pn = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) pn = P_W'(i);
    end
    mn = MANT_W'(v) << (5'd31 - 5'(pn));
  end

  always_ff @(posedge clk) begin
    p_q[0] <= pn;
    m_q[0] <= mn;
    f_q[0] <= '0;
  end

  // one fraction bit per stage
  for (genvar j = 1; j <= FRAC_W; j++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sh;

    assign sq = (2*MANT_W)'(m_q[j-1]) * (2*MANT_W)'(m_q[j-1]);
    assign sh = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      p_q[j] <= p_q[j-1];
      m_q[j] <= sh[MANT_W] ? sh[MANT_W:1] : sh[MANT_W-1:0];
      f_q[j] <= {f_q[j-1][FRAC_W-2:0], sh[MANT_W]};
    end
  end

  assign log_val = {p_q[FRAC_W], f_q[FRAC_W]};

endmodule

`default_nettype wire

// ----- design/gcl_exp2.sv -----
`default_nettype none

// 2^(-t), t in Q.16, result Q.32: one constant multiply per fraction bit,
// then the integer shift (17 stages)
module gcl_exp2 (
  input  logic                         clk,
  input  logic [gcl_pkg::T_W-1:0]      t,
  output logic [gcl_pkg::SHAPED_W-1:0] shaped
);
  import gcl_pkg::*;

  localparam logic [SHAPED_W-1:0] R_ONE = SHAPED_W'(1) << MANT_W;
  localparam int                  MUL_W = SHAPED_W + MANT_W;

  logic [SHAPED_W-1:0] r_q [1:FRAC_W];
  logic [Q_W-1:0]      q_q [1:FRAC_W];
  logic [FRAC_W-1:0]   f_q [1:FRAC_W];

  for (genvar k = 1; k <= FRAC_W; k++) begin : g_mul
    logic [SHAPED_W-1:0] r_prev;
    logic [Q_W-1:0]      q_prev;
    logic [FRAC_W-1:0]   f_prev;
    logic [MUL_W-1:0]    prod;

    if (k == 1) begin : g_first
      assign r_prev = R_ONE;
      assign q_prev = t[T_W-1:FRAC_W];
      assign f_prev = t[FRAC_W-1:0];
    end else begin : g_rest
      assign r_prev = r_q[k-1];
      assign q_prev = q_q[k-1];
      assign f_prev = f_q[k-1];
    end

    assign prod = MUL_W'(r_prev) * MUL_W'(K_TAB[k]);

    always_ff @(posedge clk) begin
      r_q[k] <= f_prev[FRAC_W-k] ? prod[MUL_W-1:MANT_W] : r_prev;
      q_q[k] <= q_prev;
      f_q[k] <= f_prev;
    end
  end

  // integer part: plain shift, zero once past the word
  always_ff @(posedge clk) begin
    if (q_q[FRAC_W] >= Q_W'(SHAPED_W)) begin
      shaped <= '0;
    end else begin
      shaped <= r_q[FRAC_W] >> q_q[FRAC_W];
    end
  end

endmodule

`default_nettype wire

// ----- design/gcl_level.sv -----
`default_nettype none

// One channel: multiply by the channel factor, then clamp and round to 16 bits
module gcl_level (
  input  logic                              clk,
  input  logic signed [gcl_pkg::BASE_W-1:0] base,
  input  logic signed [gcl_pkg::REG_W-1:0]  mul,
  output logic        [gcl_pkg::LVL_W-1:0]  level
);
  import gcl_pkg::*;

  localparam int SUM_W = 40 + LVL_W;

  logic signed [PROD_W-1:0] p_q;
  logic        [39:0]       pl;
  logic        [SUM_W-1:0]  scaled;

  always_ff @(posedge clk) begin
    p_q <= PROD_W'(base) * PROD_W'(mul);
  end

  // p*65535 as (p << 16) - p, round half up
  assign pl     = p_q[39:0];
  assign scaled = {pl, {LVL_W{1'b0}}} - SUM_W'(pl) + (SUM_W'(1) << 39);

  always_ff @(posedge clk) begin
    if (p_q[PROD_W-1] || (p_q == '0)) begin
      level <= '0;
    end else if (|p_q[PROD_W-2:40]) begin
      level <= '1;
    end else begin
      level <= scaled[SUM_W-1:40];
    end
  end

endmodule

`default_nettype wire

// ----- design/gamma_curve_lut_entry.sv -----
// Throughput: one entry per clock; busy stays low, a start is taken every cycle.
// Depth is set mainly by the 16-step log2 squaring chains (two, in parallel) and the 16-step exp2 chain.
// Results cannot be stalled: done is high for exactly one cycle per entry.
// Reset (rst, synchronous) empties the pipeline and restores register defaults.
`default_nettype none

module gamma_curve_lut_entry #(
  parameter int MAX_ENTRIES = gcl_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gcl_pkg::IDX_W-1:0]     entry_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcl_pkg::REG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [gcl_pkg::IDX_W-1:0]     entry_index_out,
  output logic [gcl_pkg::LVL_W-1:0]     red_level,
  output logic [gcl_pkg::LVL_W-1:0]     green_level,
  output logic [gcl_pkg::LVL_W-1:0]     blue_level
);
  import gcl_pkg::*;

  // stage numbers along the delay line
  localparam int ST_ZERO = PIPE_LAT - 4;

  logic [SIZE_W-1:0] table_size;
  logic [REG_W-1:0]  gamma_exponent;
  logic [REG_W-1:0]  gain;
  logic [REG_W-1:0]  lift;
  logic [REG_W-1:0]  red_multiplier;
  logic [REG_W-1:0]  green_multiplier;
  logic [REG_W-1:0]  blue_multiplier;

  logic              accept;
  logic [SIZE_W-1:0] size_c;
  logic [SIZE_W-1:0] sm1_c;
  logic [IDX_W-1:0]  idx_c;

  logic [SIZE_W-1:0] sm1_a;
  logic [IDX_W-1:0]  idx_a;
  gcl_tag_t          tag [0:PIPE_LAT-1];

  logic [LOG_W-1:0]    log_size;
  logic [LOG_W-1:0]    log_idx;
  logic [LOG_W-1:0]    e_q;
  logic [REG_W-1:0]    g_eff;
  logic [36:0]         t_sum;
  logic [T_W-1:0]      t_q;
  logic [SHAPED_W-1:0] shaped;
  logic [SHAPED_W-1:0] shaped_eff;
  logic [47:0]         gain_sum;
  logic signed [BASE_W-1:0] lift_ext;
  logic signed [BASE_W-1:0] base_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size       <= TABLE_SIZE_RST;
      gamma_exponent   <= ONE_Q12;
      gain             <= ONE_Q12;
      lift             <= LIFT_RST;
      red_multiplier   <= ONE_Q12;
      green_multiplier <= ONE_Q12;
      blue_multiplier  <= ONE_Q12;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TABLE_SIZE: table_size       <= cfg_data[SIZE_W-1:0];
        REG_GAMMA:      gamma_exponent   <= cfg_data;
        REG_GAIN:       gain             <= cfg_data;
        REG_LIFT:       lift             <= cfg_data;
        REG_RED_MUL:    red_multiplier   <= cfg_data;
        REG_GREEN_MUL:  green_multiplier <= cfg_data;
        REG_BLUE_MUL:   blue_multiplier  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: clamp size and index
  always_comb begin
    size_c = table_size;
    if (table_size < SIZE_W'(2)) begin
      size_c = SIZE_W'(2);
    end else if (32'(table_size) > 32'(MAX_ENTRIES)) begin
      size_c = SIZE_W'(MAX_ENTRIES);
    end
    sm1_c = size_c - SIZE_W'(1);
    idx_c = ({1'b0, entry_index} > sm1_c) ? sm1_c[IDX_W-1:0] : entry_index;
  end

  always_ff @(posedge clk) begin
    sm1_a <= sm1_c;
    idx_a <= idx_c;
  end

  // tag delay line, valid bits cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PIPE_LAT; j++) tag[j].valid <= 1'b0;
    end else begin
      tag[0].valid <= accept;
      for (int j = 1; j < PIPE_LAT; j++) tag[j].valid <= tag[j-1].valid;
    end
    tag[0].idx  <= idx_c;
    tag[0].zero <= (idx_c == '0);
    for (int j = 1; j < PIPE_LAT; j++) begin
      tag[j].idx  <= tag[j-1].idx;
      tag[j].zero <= tag[j-1].zero;
    end
  end

  // stages 1..17: both logarithms
  gcl_log2 u_log_size (
    .clk     (clk),
    .v       (sm1_a),
    .log_val (log_size)
  );

  gcl_log2 u_log_idx (
    .clk     (clk),
    .v       ({1'b0, idx_a}),
    .log_val (log_idx)
  );

  // stage 18: log difference; stage 19: scale by gamma
  assign g_eff = (gamma_exponent == '0) ? ONE_Q12 : gamma_exponent;
  assign t_sum = 37'(g_eff) * 37'(e_q) + 37'd2048;

  always_ff @(posedge clk) begin
    e_q <= log_size - log_idx;
    t_q <= t_sum[36:12];
  end

  // stages 20..36: power
  gcl_exp2 u_exp (
    .clk    (clk),
    .t      (t_q),
    .shaped (shaped)
  );

  // stage 37: lift + gain * shaped
  assign shaped_eff = tag[ST_ZERO].zero ? '0 : shaped;
  assign gain_sum   = 48'(gain) * 48'(shaped_eff) + 48'h8000;
  assign lift_ext   = $signed({{(BASE_W-REG_W-14){lift[REG_W-1]}}, lift, 14'b0});

  always_ff @(posedge clk) begin
    base_q <= lift_ext + $signed({2'b00, gain_sum[47:16]});
  end

  // stages 38..39: per-channel product and rounding
  gcl_level u_red (
    .clk   (clk),
    .base  (base_q),
    .mul   ($signed(red_multiplier)),
    .level (red_level)
  );

  gcl_level u_green (
    .clk   (clk),
    .base  (base_q),
    .mul   ($signed(green_multiplier)),
    .level (green_level)
  );

  gcl_level u_blue (
    .clk   (clk),
    .base  (base_q),
    .mul   ($signed(blue_multiplier)),
    .level (blue_level)
  );

  assign done            = tag[PIPE_LAT-1].valid;
  assign entry_index_out = tag[PIPE_LAT-1].idx;

endmodule

`default_nettype wire

// ----- design/gcl_checker.sv -----
`default_nettype none

module gcl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [gcl_pkg::IDX_W-1:0] entry_index,
  input logic                      done,
  input logic [gcl_pkg::IDX_W-1:0] entry_index_out
);
  import gcl_pkg::*;

  // delay from the accepting edge to the edge on which done is sampled
  localparam int DLY = PIPE_LAT;

  // every accepted beat produces a done strobe
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##DLY done)
    else $error("accepted beat did not produce a result");

  // no result without a matching accepted beat
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, DLY))
    else $error("result without accepted beat");

  // index out is the clamped input, never above it
  a_idx_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_index_out <= $past(entry_index, DLY)))
    else $error("index out above input index");

endmodule

bind gamma_curve_lut_entry gcl_checker u_gcl_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .entry_index     (entry_index),
  .done            (done),
  .entry_index_out (entry_index_out)
);

`default_nettype wire

// ----- verif/gamma_curve_lut_entry_tb.sv -----
`default_nettype none

module gamma_curve_lut_entry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcl_pkg::*;

  // Unused register slot, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int MAX_SIZE = 4096;

  // Expected entry: clamped index and three levels
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [LVL_W-1:0] lvl [3];
  } entry_t;

  // Curve predictor and store of expected entries
  class curve_board;
    logic [SIZE_W-1:0] size_reg;
    logic [REG_W-1:0]  gamma_reg, gain_reg, lift_reg;
    logic [REG_W-1:0]  mul_reg [3];
    logic [63:0]       root_tab [17];
    entry_t            expected_q [$];
    int                mismatches;

    function new();
      logic [63:0] r, t;
      root_tab[0] = 64'h8000_0000;
      for (int k = 1; k <= 16; k++) begin
        r = 0;
        for (int b = 31; b >= 0; b--) begin
          t = r | (64'd1 << b);
          if (t * t <= (root_tab[k-1] << 32)) r = t;
        end
        root_tab[k] = r;
      end
      mismatches = 0;
      set_defaults();
    endfunction

    function void set_defaults();
      size_reg = 13'd1024;
      gamma_reg = 16'd4096;
      gain_reg = 16'd4096;
      lift_reg = 16'd0;
      foreach (mul_reg[c]) mul_reg[c] = 16'd4096;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] ix, logic [REG_W-1:0] d);
      case (ix)
        REG_TABLE_SIZE: size_reg = d[SIZE_W-1:0];
        REG_GAMMA:      gamma_reg = d;
        REG_GAIN:       gain_reg = d;
        REG_LIFT:       lift_reg = d;
        REG_RED_MUL:    mul_reg[0] = d;
        REG_GREEN_MUL:  mul_reg[1] = d;
        REG_BLUE_MUL:   mul_reg[2] = d;
        default: ;
      endcase
    endfunction

    // log2 in Q.16 by mantissa squaring
    function logic [63:0] log2_fix(logic [63:0] v);
      int p;
      logic [63:0] m, frac;
      p = 0;
      while (p < 31 && (v >> (p + 1)) != 0) p++;
      m = (v << (31 - p)) & 64'hFFFF_FFFF;
      frac = 0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      return (64'(p) << 16) | frac;
    endfunction

    function logic [LVL_W-1:0] level(longint base, logic [REG_W-1:0] mul);
      longint p;
      logic [63:0] u;
      p = base * longint'($signed(mul));
      if (p <= 0) return '0;
      if (p >= (64'sd1 <<< 40)) return 16'hFFFF;
      u = (64'(p) * 65535 + (64'd1 << 39)) >> 40;
      return u[LVL_W-1:0];
    endfunction

    function void note_entry(logic [IDX_W-1:0] in_idx);
      entry_t      e;
      logic [63:0] s, ix, g, ex, t, q, f, r, shaped;
      longint      base;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > MAX_SIZE) s = MAX_SIZE;
      ix = in_idx;
      if (ix > s - 1) ix = s - 1;
      g = (gamma_reg == 0) ? 64'd4096 : 64'(gamma_reg);
      if (ix == 0) begin
        shaped = 0;
      end else begin
        ex = log2_fix(s - 1) - log2_fix(ix);
        t = (g * ex + 2048) >> 12;
        q = t >> 16;
        f = t & 64'hFFFF;
        r = 64'h1_0000_0000;
        for (int k = 1; k <= 16; k++)
          if (f[16-k]) r = (r * root_tab[k]) >> 32;
        shaped = (q >= 33) ? 64'd0 : (r >> q);
      end
      base = longint'($signed(lift_reg)) * 16384
           + longint'((64'(gain_reg) * shaped + (64'd1 << 15)) >> 16);
      e.idx = ix[IDX_W-1:0];
      for (int c = 0; c < 3; c++) e.lvl[c] = level(base, mul_reg[c]);
      expected_q.push_back(e);
    endfunction

    function void check_entry(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] r,
                              logic [LVL_W-1:0] g, logic [LVL_W-1:0] b);
      entry_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected entry idx=%0d", idx);
        return;
      end
      e = expected_q.pop_front();
      if (idx !== e.idx || r !== e.lvl[0] || g !== e.lvl[1] || b !== e.lvl[2]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("entry mismatch: exp idx=%0d r=%0d g=%0d b=%0d, got idx=%0d r=%0d g=%0d b=%0d",
                   e.idx, e.lvl[0], e.lvl[1], e.lvl[2], idx, r, g, b);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done;
  logic [IDX_W-1:0] entry_index, entry_index_out;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  logic [LVL_W-1:0] red_level, green_level, blue_level;

  curve_board sb = new();

  gamma_curve_lut_entry u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .entry_index(entry_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .entry_index_out(entry_index_out),
    .red_level(red_level), .green_level(green_level), .blue_level(blue_level)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitor: accepted beats feed the predictor, strobed entries get checked
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_entry(entry_index);
      if (done) sb.check_entry(entry_index_out, red_level, green_level, blue_level);
    end
  end

  // Start stays high across back-to-back beats
  task automatic send_entry(logic [IDX_W-1:0] ix, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    entry_index <= ix;
    do @(posedge clk); while (busy);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] ix, logic [REG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(logic [REG_W-1:0] sz, logic [REG_W-1:0] gm, logic [REG_W-1:0] gn,
                         logic [REG_W-1:0] lf, logic [REG_W-1:0] rm, logic [REG_W-1:0] gmul,
                         logic [REG_W-1:0] bm);
    cfg_write(REG_TABLE_SIZE, sz);
    cfg_write(REG_GAMMA, gm);
    cfg_write(REG_GAIN, gn);
    cfg_write(REG_LIFT, lf);
    cfg_write(REG_RED_MUL, rm);
    cfg_write(REG_GREEN_MUL, gmul);
    cfg_write(REG_BLUE_MUL, bm);
    cfg_write(REG_UNUSED, REG_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_run(int n);
    bit steady;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady = 1'($urandom_range(0, 1));
      send_entry(IDX_W'($urandom_range(0, 4095)), steady ? 0 : int'($urandom_range(0, 5)));
    end
  endtask

  initial begin
    start = 0; entry_index = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default curve around the table ends
    send_entry(0, 0); send_entry(1, 0); send_entry(512, 0); send_entry(1022, 0);
    send_entry(1023, 0); send_entry(1024, 2); send_entry(4095, 0);
    drain();
    // Size below two, zero exponent, negative lift, mixed-sign multipliers
    set_all(16'd0, 16'd0, 16'd8192, 16'h8000, 16'h7FFF, 16'h8000, 16'd0);
    send_entry(0, 0); send_entry(1, 0); send_entry(4095, 1);
    drain();
    set_all(16'd1, 16'd1, 16'hFFFF, 16'h7FFF, 16'd4096, 16'hF000, 16'h0001);
    send_entry(0, 0); send_entry(1, 0); send_entry(2, 0);
    drain();
    // Size above the maximum, steepest exponent
    set_all(16'h1FFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd4096, 16'd2048, 16'h7FFF);
    send_entry(0, 0); send_entry(1, 0); send_entry(2, 0); send_entry(2048, 0);
    send_entry(4094, 0); send_entry(4095, 0);
    drain();
    set_all(16'd4096, 16'd1, 16'd0, 16'h4000, 16'd4096, 16'd4096, 16'd4096);
    send_entry(1, 0); send_entry(4095, 3); send_entry(3000, 0);
    drain();

    // Random phases: half with plain gamma-like settings, half with anything
    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 2 == 0)
        set_all(REG_W'($urandom_range(2, 4096)), REG_W'($urandom_range(1024, 16384)),
                REG_W'($urandom_range(0, 8192)), REG_W'($urandom_range(0, 4096)),
                REG_W'($urandom_range(0, 8192)), REG_W'($urandom_range(0, 8192)),
                REG_W'($urandom_range(0, 8192)));
      else
        set_all(REG_W'($urandom_range(0, 8191)), REG_W'($urandom), REG_W'($urandom),
                REG_W'($urandom), REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
      random_run(150);
      drain();
    end

    repeat (PIPE_LAT + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
